// ----- src/akvt_pkg.sv -----
// Package for the associative key/value table: sizes, operation and status
// codes, and the structs passed between the top level and the slot cells.
// No dependencies.
package akvt_pkg;

    // Table geometry
    localparam int ENTRIES     = 64;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = $clog2(ENTRIES + 1);

    // Fixed field widths on the streams
    localparam int OP_W        = 2;
    localparam int IN_KEY_W    = 64;
    localparam int IN_VALUE_W  = 64;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 7;
    localparam int IN_DATA_W   = 136;
    localparam int OUT_DATA_W  = 80;

    // Request operation codes; the unused code acts as a lookup
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ASSIGN = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Commands broadcast to every cell during the update cycle
    typedef struct packed {
        logic ins;   // insert into the lowest free cell
        logic upd;   // overwrite the value in the matching cell
        logic del;   // free the matching cell
    } t_cell_ctl;

    // Data handed from each cell to its upper neighbor
    typedef struct packed {
        logic               free_seen;  // a free cell sits at or below here
        logic               hit_seen;   // a matching cell sits at or below here
        logic [VALUE_W-1:0] rd_value;   // value of the matching cell, else 0
    } t_chain;

    // Per-cell status exported to the top level
    typedef struct packed {
        logic valid;
        logic match;
    } t_cell_stat;

endpackage

// ----- src/akvt_cell.sv -----
// One slot cell of the key/value table: holds a valid bit, key and value,
// compares against the broadcast key and extends the neighbor chain.
// Depends on akvt_pkg.
module akvt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [akvt_pkg::KEY_W-1:0]   i_key,
    input  logic [akvt_pkg::VALUE_W-1:0] i_value,
    input  akvt_pkg::t_cell_ctl         i_ctl,
    input  akvt_pkg::t_chain            i_chain,
    output akvt_pkg::t_chain            o_chain,
    output akvt_pkg::t_cell_stat        o_stat
);

    logic                        r_valid;
    logic                        r_match;
    logic [akvt_pkg::KEY_W-1:0]   r_key;
    logic [akvt_pkg::VALUE_W-1:0] r_value;
    logic                        w_grant;

    // This cell is the lowest free one
    assign w_grant = !r_valid && !i_chain.free_seen;

    // Chain toward the upper neighbor
    always_comb begin
        o_chain.free_seen = i_chain.free_seen || !r_valid;
        o_chain.hit_seen  = i_chain.hit_seen || r_match;
        o_chain.rd_value  = i_chain.rd_value | (r_match ? r_value : '0);
    end

    assign o_stat.valid = r_valid;
    assign o_stat.match = r_match;

    // Valid bit and registered compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.ins && w_grant) begin
                r_valid <= 1'b1;
            end else if (i_ctl.del && r_match) begin
                r_valid <= 1'b0;
            end
            r_match <= r_valid && (r_key == i_key);
        end
    end

    // Key and value storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_grant) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.upd && r_match) begin
            r_value <= i_value;
        end
    end

endmodule

// ----- src/associative_key_value_table_core.sv -----
// Associative key/value table with unique keys and a live count.
// A request beat on the slave stream is a lookup, assign or delete; one
// result beat comes out on the master stream for every request.
//
// Usage:
//   s_axis_tdata carries operation, key and value; m_axis_tdata returns
//   found, read_value, status and entry_count.
//   The table is a row of slot cells. A request is registered on accept,
//   compared in every cell in the next cycle, and in the cycle after that
//   the cell chain yields the hit, the read value and the lowest free cell;
//   the table is written and the result is loaded once the output register
//   is free. The next request is taken only in the same cycle that the
//   previous result is loaded into the output register, or while idle.
//   Reset clears every valid bit and the count at once: the table is empty
//   and ready in the first cycle after reset.
//   A stalled receiver holds the result in the output register; one more
//   request may be accepted meanwhile and waits in the update cycle until
//   the output register frees up.
// Depends on akvt_pkg and akvt_cell.
module associative_key_value_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation[1:0], key[65:2], value[129:66], zero pad[135:130]
    input  logic [akvt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found[0], read_value[64:1], status[66:65], entry_count[73:67], pad[79:74]
    output logic [akvt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    localparam int N = akvt_pkg::ENTRIES;

    t_state                          r_state;
    logic                            r_out_valid;
    logic [akvt_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic [akvt_pkg::COUNT_W-1:0]     r_count;
    akvt_pkg::t_op                   r_op;
    logic [akvt_pkg::KEY_W-1:0]       r_key;
    logic [akvt_pkg::VALUE_W-1:0]     r_value;

    logic                            w_commit;
    logic                            w_in_acc;
    logic                            w_hit;
    logic                            w_any_free;
    akvt_pkg::t_cell_ctl             w_ctl;
    akvt_pkg::t_chain                w_chain [N+1];
    akvt_pkg::t_cell_stat            w_stat  [N];
    logic [N-1:0]                    w_valid_vec;
    logic [N-1:0]                    w_match_vec;

    logic                            n_found;
    logic [akvt_pkg::VALUE_W-1:0]     n_rd;
    akvt_pkg::t_status               n_status;
    logic [akvt_pkg::COUNT_W-1:0]     n_count;

    // Handshake
    assign w_commit      = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE) || w_commit;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Request register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= akvt_pkg::t_op'(s_axis_tdata[1:0]);
            r_key   <= s_axis_tdata[2 +: akvt_pkg::KEY_W];
            r_value <= s_axis_tdata[2 + akvt_pkg::IN_KEY_W +: akvt_pkg::VALUE_W];
        end
    end

    // Cell row
    assign w_chain[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        akvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_value (r_value),
            .i_ctl   (w_ctl),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_stat  (w_stat[g])
        );
        assign w_valid_vec[g] = w_stat[g].valid;
        assign w_match_vec[g] = w_stat[g].match;
    end

    assign w_hit      = w_chain[N].hit_seen;
    assign w_any_free = w_chain[N].free_seen;

    // Operation decode for the update cycle
    always_comb begin
        n_found  = w_hit;
        n_rd     = '0;
        n_status = akvt_pkg::ST_OK;
        n_count  = r_count;
        w_ctl    = '0;
        case (r_op)
            akvt_pkg::OP_ASSIGN: begin
                if (w_hit) begin
                    w_ctl.upd = w_commit;
                end else if (w_any_free) begin
                    w_ctl.ins = w_commit;
                    n_count   = r_count + akvt_pkg::COUNT_W'(1);
                end else begin
                    n_status = akvt_pkg::ST_FULL;
                end
            end
            akvt_pkg::OP_DELETE: begin
                if (w_hit) begin
                    w_ctl.del = w_commit;
                    n_count   = r_count - akvt_pkg::COUNT_W'(1);
                end else begin
                    n_status = akvt_pkg::ST_MISSING;
                end
            end
            default: begin
                if (w_hit) begin
                    n_rd = w_chain[N].rd_value;
                end else begin
                    n_status = akvt_pkg::ST_MISSING;
                end
            end
        endcase
    end

    // Sequencer, live count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= w_in_acc ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_out_data  <= {
                    (akvt_pkg::OUT_DATA_W - 74)'(0),
                    akvt_pkg::OUT_COUNT_W'(n_count),
                    n_status,
                    64'(n_rd),
                    n_found
                };
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == r_count)
        else $error("live count differs from number of valid cells");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("more than one cell matches the key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= akvt_pkg::COUNT_W'(N))
        else $error("live count above table size");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("result not presented after update");

endmodule
